// ----- hdl/rstm_pkg.sv -----
// Shared types and constants of the range sensor trimmed-mean tracker.
// No dependencies; every other file of the block depends on this package.
package rstm_pkg;

    localparam int unsigned WINDOW_DEF   = 8;
    localparam int unsigned CHANNELS_DEF = 4;
    localparam int unsigned OUT_CH       = 4;
    localparam int unsigned DIST_W       = 16;
    localparam int unsigned HOLD_W       = 8;
    localparam int unsigned CFG_AW       = 5;
    localparam int unsigned CFG_DW       = 32;

    localparam logic [DIST_W-1:0] NONE_RST = 16'hFFFF;
    localparam logic [HOLD_W-1:0] HOLD_RST = 8'd4;

    // Word kinds on the input channel.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Register indexes (byte address / 4).
    localparam logic [2:0] REG_NONE_CODE = 3'd0;
    localparam logic [2:0] REG_OFF_FRONT = 3'd1;
    localparam logic [2:0] REG_OFF_LEFT  = 3'd2;
    localparam logic [2:0] REG_OFF_BACK  = 3'd3;
    localparam logic [2:0] REG_OFF_RIGHT = 3'd4;
    localparam logic [2:0] REG_HOLD      = 3'd5;

    typedef struct packed {
        logic [DIST_W-1:0]             none_code;
        logic [OUT_CH-1:0][DIST_W-1:0] offset;
        logic [HOLD_W-1:0]             hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic              clr;
        logic              vld;
        logic              last;
        logic [DIST_W-1:0] dat;
    } t_mean_ctl;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] mean;
    } t_mean_sts;

endpackage

// ----- hdl/rstm_if.sv -----
// Valid/ready channel interfaces of the range sensor trimmed-mean tracker.
// Depends on rstm_pkg for the field widths.
interface rstm_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [1:0]                 channel;
    logic [rstm_pkg::DIST_W-1:0] distance;

    modport source (output valid, action, channel, distance, input ready);
    modport sink   (input valid, action, channel, distance, output ready);
endinterface

interface rstm_out_if;
    logic                       valid;
    logic                       ready;
    logic [rstm_pkg::DIST_W-1:0] range_ch0;
    logic [rstm_pkg::DIST_W-1:0] range_ch1;
    logic [rstm_pkg::DIST_W-1:0] range_ch2;
    logic [rstm_pkg::DIST_W-1:0] range_ch3;
    logic                       fresh_ch0;
    logic                       fresh_ch1;
    logic                       fresh_ch2;
    logic                       fresh_ch3;

    modport source (output valid, range_ch0, range_ch1, range_ch2, range_ch3,
                    fresh_ch0, fresh_ch1, fresh_ch2, fresh_ch3, input ready);
    modport sink   (input valid, range_ch0, range_ch1, range_ch2, range_ch3,
                    fresh_ch0, fresh_ch1, fresh_ch2, fresh_ch3, output ready);
endinterface

// ----- hdl/rstm_cfg_regs.sv -----
// APB-style configuration register file of the trimmed-mean tracker.
// Depends on rstm_pkg for the register map and the t_cfg struct.
module rstm_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rstm_pkg::CFG_AW-1:0] paddr,
    input  logic [rstm_pkg::CFG_DW-1:0] pwdata,
    output logic [rstm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    output rstm_pkg::t_cfg              o_cfg
);
    import rstm_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.none_code  <= NONE_RST;
            r_cfg.offset     <= '0;
            r_cfg.hold_ticks <= HOLD_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_NONE_CODE: r_cfg.none_code  <= pwdata[DIST_W-1:0];
                REG_OFF_FRONT: r_cfg.offset[0]  <= pwdata[DIST_W-1:0];
                REG_OFF_LEFT:  r_cfg.offset[1]  <= pwdata[DIST_W-1:0];
                REG_OFF_BACK:  r_cfg.offset[2]  <= pwdata[DIST_W-1:0];
                REG_OFF_RIGHT: r_cfg.offset[3]  <= pwdata[DIST_W-1:0];
                REG_HOLD:      r_cfg.hold_ticks <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NONE_CODE: prdata = CFG_DW'(r_cfg.none_code);
            REG_OFF_FRONT: prdata = CFG_DW'(r_cfg.offset[0]);
            REG_OFF_LEFT:  prdata = CFG_DW'(r_cfg.offset[1]);
            REG_OFF_BACK:  prdata = CFG_DW'(r_cfg.offset[2]);
            REG_OFF_RIGHT: prdata = CFG_DW'(r_cfg.offset[3]);
            REG_HOLD:      prdata = CFG_DW'(r_cfg.hold_ticks);
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- hdl/rstm_mean_unit.sv -----
// Shared mean unit: accumulates sum, max and min of a window streamed in,
// trims if WINDOW > 3, then divides by the constant entry count with one
// reciprocal multiply. Depends on rstm_pkg for the control and status structs.
module rstm_mean_unit #(
    parameter int unsigned WINDOW = rstm_pkg::WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rstm_pkg::t_mean_ctl   i_ctl,
    output rstm_pkg::t_mean_sts   o_sts
);
    import rstm_pkg::*;

    localparam int unsigned SW    = DIST_W + $clog2(WINDOW + 1);
    localparam bit          TRIM  = (WINDOW > 3);
    localparam int unsigned DIV   = TRIM ? (WINDOW - 2) : WINDOW;
    localparam int unsigned DIV_L = $clog2(DIV);
    localparam int unsigned SHIFT = SW + DIV_L;
    localparam int unsigned PW    = 2 * SW + 1;
    // Rounded-up reciprocal: the floor quotient is exact for every sum below 2**SW.
    localparam logic [SW:0] RECIP = (SW + 1)'((64'd1 << SHIFT) / 64'(DIV) + 64'd1);

    typedef enum logic [1:0] {M_ACC, M_TRIM, M_MUL} t_mstate;

    t_mstate           r_state;
    logic [SW-1:0]     r_sum;
    logic [DIST_W-1:0] r_hi;
    logic [DIST_W-1:0] r_lo;
    logic [DIST_W-1:0] r_q;
    logic              r_done;
    logic [PW-1:0]     prod;

    assign o_sts.done = r_done;
    assign o_sts.mean = r_q;
    assign prod       = PW'(r_sum) * PW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_ACC;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == M_MUL);
            unique case (r_state)
                M_ACC: begin
                    if (i_ctl.clr) begin
                        r_sum <= '0;
                        r_hi  <= '0;
                        r_lo  <= '1;
                    end else if (i_ctl.vld) begin
                        r_sum <= r_sum + SW'(i_ctl.dat);
                        if (i_ctl.dat > r_hi) r_hi <= i_ctl.dat;
                        if (i_ctl.dat < r_lo) r_lo <= i_ctl.dat;
                        if (i_ctl.last) r_state <= M_TRIM;
                    end
                end
                M_TRIM: begin
                    if (TRIM) r_sum <= r_sum - SW'(r_hi) - SW'(r_lo);
                    r_state <= M_MUL;
                end
                M_MUL: begin
                    r_q     <= prod[SHIFT +: DIST_W];
                    r_state <= M_ACC;
                end
                default: r_state <= M_ACC;
            endcase
        end
    end

endmodule

// ----- hdl/range_sensor_trimmed_mean_tracker.sv -----
// Range sensor trimmed-mean tracker. Each input word is a distance sample
// for one channel or a time tick; each word yields one output word with the
// reported range and fresh flag of all four channels. A tick, or a sample
// that does not complete its channel's window, passes from the update state
// to the finish state, which loads the output register. A sample that
// completes the window goes from the update state through the scan state,
// where the window is read back one entry a cycle through the single read
// port of the window memory, and the mean state, where the shared mean unit
// trims (for windows of more than three entries) and divides by the constant
// entry count with one reciprocal multiply, on to the finish state. The
// input is not ready while a word is in work; a finished word waits in the
// output register while the next input word is taken, and a word that
// finds the output register still full waits until it drains. The window
// memory is not cleared at reset; a mean is formed only after a channel has
// filled every slot of its window, so no clearing pass is needed.
module range_sensor_trimmed_mean_tracker #(
    parameter int unsigned WINDOW   = rstm_pkg::WINDOW_DEF,
    parameter int unsigned CHANNELS = rstm_pkg::CHANNELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rstm_in_if.sink                     i_in,
    rstm_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rstm_pkg::CFG_AW-1:0] paddr,
    input  logic [rstm_pkg::CFG_DW-1:0] pwdata,
    output logic [rstm_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import rstm_pkg::*;

    localparam int unsigned CW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned SLW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned AW        = CW + SLW;
    localparam int unsigned MEM_DEPTH = 2 ** AW;
    localparam logic [SLW-1:0] K_LAST = SLW'(WINDOW - 1);

    typedef enum logic [2:0] {S_IDLE, S_UPD, S_SCAN, S_MEAN, S_FIN} t_state;

    t_cfg      cfg;
    t_mean_ctl mean_ctl;
    t_mean_sts mean_sts;

    t_state            r_state;
    logic              r_act;
    logic [1:0]        r_chan;
    logic [DIST_W-1:0] r_dist;
    logic [SLW-1:0]    r_k;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [DIST_W-1:0] r_rd_dat;
    logic [DIST_W-1:0] r_win_mem [MEM_DEPTH];

    logic [SLW-1:0]    r_slot  [CHANNELS];
    logic              r_fresh [CHANNELS];
    logic [HOLD_W-1:0] r_hold  [CHANNELS];
    logic [DIST_W-1:0] r_rep   [CHANNELS];
    logic [DIST_W-1:0] n_rep   [CHANNELS];

    logic              r_out_vld;
    logic [DIST_W-1:0] r_out_rng [OUT_CH];
    logic              r_out_frs [OUT_CH];
    logic [DIST_W-1:0] w_out_rng [OUT_CH];
    logic              w_out_frs [OUT_CH];

    logic [CW-1:0]     ch_idx;
    logic              ch_ok;
    logic [DIST_W-1:0] off;
    logic [DIST_W-1:0] adj;
    logic [SLW-1:0]    cur_slot;
    logic              wrap;
    logic              is_sample;
    logic              mem_we;
    logic              out_load;

    rstm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rstm_mean_unit #(.WINDOW(WINDOW)) u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mean_ctl),
        .o_sts   (mean_sts)
    );

    assign ch_idx    = CW'(r_chan);
    assign ch_ok     = (32'(r_chan) < CHANNELS);
    assign is_sample = (r_act == ACT_SAMPLE);
    assign off       = cfg.offset[r_chan];
    assign cur_slot  = r_slot[ch_idx];
    assign wrap      = (cur_slot == K_LAST);
    assign mem_we    = (r_state == S_UPD) && is_sample && ch_ok;
    assign out_load  = (r_state == S_FIN) && (!r_out_vld || o_out.ready);

    // Below the offset clamps to zero first; codes at or above none pass as is.
    always_comb begin
        if (r_dist < off) begin
            adj = '0;
        end else if (r_dist < cfg.none_code) begin
            adj = r_dist - off;
        end else begin
            adj = r_dist;
        end
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_rep[c] = r_fresh[c] ? r_rep[c] : cfg.none_code;
        end
    end

    assign mean_ctl.clr  = mem_we && wrap;
    assign mean_ctl.vld  = r_rd_vld;
    assign mean_ctl.last = r_rd_last;
    assign mean_ctl.dat  = r_rd_dat;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_win_mem[{ch_idx, cur_slot}] <= adj;
        r_rd_dat <= r_win_mem[{ch_idx, r_k}];
    end

    for (genvar g = 0; g < OUT_CH; g++) begin : g_out
        if (g < CHANNELS) begin : g_live
            assign w_out_rng[g] = n_rep[g];
            assign w_out_frs[g] = r_fresh[g];
        end else begin : g_tied
            assign w_out_rng[g] = '0;
            assign w_out_frs[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_k       <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_slot[c]  <= '0;
                r_fresh[c] <= 1'b0;
                r_hold[c]  <= '0;
                r_rep[c]   <= '0;
            end
        end else begin
            if (out_load) r_out_vld <= 1'b1;
            else if (o_out.ready) r_out_vld <= 1'b0;
            r_rd_vld  <= (r_state == S_SCAN);
            r_rd_last <= (r_state == S_SCAN) && (r_k == K_LAST);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act   <= i_in.action;
                        r_chan  <= i_in.channel;
                        r_dist  <= i_in.distance;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (is_sample) begin
                        if (ch_ok) begin
                            r_fresh[ch_idx] <= 1'b1;
                            r_hold[ch_idx]  <= cfg.hold_ticks;
                            r_slot[ch_idx]  <= wrap ? '0 : cur_slot + 1'b1;
                        end
                        if (ch_ok && wrap) begin
                            r_k     <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            if (r_hold[c] != '0) begin
                                r_hold[c] <= r_hold[c] - 1'b1;
                                if (r_hold[c] == HOLD_W'(1)) r_fresh[c] <= 1'b0;
                            end
                        end
                        r_state <= S_FIN;
                    end
                end
                S_SCAN: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == K_LAST) r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (mean_sts.done) begin
                        r_rep[ch_idx] <= mean_sts.mean;
                        r_state       <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Stale channels take the current none code into their state.
                    if (out_load) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_rep[c] <= n_rep[c];
                        end
                        for (int c = 0; c < OUT_CH; c++) begin
                            r_out_rng[c] <= w_out_rng[c];
                            r_out_frs[c] <= w_out_frs[c];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.range_ch0 = r_out_rng[0];
    assign o_out.range_ch1 = r_out_rng[1];
    assign o_out.range_ch2 = r_out_rng[2];
    assign o_out.range_ch3 = r_out_rng[3];
    assign o_out.fresh_ch0 = r_out_frs[0];
    assign o_out.fresh_ch1 = r_out_frs[1];
    assign o_out.fresh_ch2 = r_out_frs[2];
    assign o_out.fresh_ch3 = r_out_frs[3];

endmodule

// ----- hdl/rstm_checker.sv -----
// Port-level checks of the trimmed-mean tracker and the bind that attaches
// them to the top level. Depends on rstm_pkg for the range width.
module rstm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rstm_pkg::DIST_W-1:0] i_range0,
    input logic [rstm_pkg::DIST_W-1:0] i_range1,
    input logic [rstm_pkg::DIST_W-1:0] i_range2,
    input logic [rstm_pkg::DIST_W-1:0] i_range3
);
    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // A stalled output word keeps its ranges.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_range0)
            && $stable(i_range1) && $stable(i_range2) && $stable(i_range3))
        else $error("output word changed while stalled");

    // One word at a time: the input closes right after an accept.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input accepted a second word while busy");

    // A new output word never appears in the cycle right after an accept.
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_acc))
        else $error("output word appeared too early");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind range_sensor_trimmed_mean_tracker rstm_checker u_rstm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_range0    (o_out.range_ch0),
    .i_range1    (o_out.range_ch1),
    .i_range2    (o_out.range_ch2),
    .i_range3    (o_out.range_ch3)
);
